// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the frame table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pfl_pkg.sv -----
`timescale 1ns / 1ps

package pfl_pkg;

   localparam int NUM_FRAMES_DEFAULT  = 16;
   localparam int PAGE_BITS_DEFAULT   = 16;
   localparam int STAMP_LIMIT_DEFAULT = 32000;

   localparam int PAGE_FIELD_W  = 16;
   localparam int STAMP_W       = 16;
   localparam int PIN_W         = 8;
   localparam int TOTAL_W       = 32;
   localparam int FRAME_FIELD_W = 4;
   localparam int FIU_W         = 5;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   localparam int FRAME_WORD_W_DEFAULT = PAGE_BITS_DEFAULT + PIN_W + 1 + STAMP_W;

   localparam logic [FIU_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_PIN,
      OP_UNPIN,
      OP_MARK_DIRTY,
      OP_FORCE
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_NOT_RESIDENT,
      STATUS_ALL_PINNED
   } status_type;

   typedef enum logic {
      REG_REPLACE_MODE,
      REG_FRAMES_IN_USE
   } reg_index_type;

   typedef enum logic {
      MODE_FIFO,
      MODE_LRU
   } replace_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_DECIDE,
      ST_MIN,
      ST_MIN_WAIT,
      ST_SUB,
      ST_SUB_WAIT,
      ST_WRITE
   } state_type;

   // Which sweep a frame word coming back from the RAM belongs to.
   typedef enum logic [1:0] {
      PASS_SCAN,
      PASS_MIN,
      PASS_SUB
   } pass_type;

   typedef struct packed {
      op_type                  operation;
      logic [PAGE_FIELD_W-1:0] page_number;
   } req_type;

   typedef struct packed {
      logic [FRAME_FIELD_W-1:0] frame_index;
      status_type               status;
      logic                     hit;
      logic                     read_page;
      logic                     write_back;
      logic [PAGE_FIELD_W-1:0]  written_page;
      logic [PIN_W-1:0]         pin_count;
      logic [TOTAL_W-1:0]       read_total;
      logic [TOTAL_W-1:0]       write_total;
   } rsp_type;

endpackage

// ----- rtl/pfl_stream_if.sv -----
`timescale 1ns / 1ps

interface pfl_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/pfl_frame_ram.sv -----
`timescale 1ns / 1ps

module pfl_frame_ram #(
   parameter int DEPTH  = pfl_pkg::NUM_FRAMES_DEFAULT,
   parameter int WORD_W = pfl_pkg::FRAME_WORD_W_DEFAULT
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WORD_W-1:0]        rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_W-1:0]        wr_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/page_frame_table_fifo_lru_core.sv -----
// Frame table of a page buffer pool with FIFO or LRU replacement. Every
// transaction (pin, unpin, mark dirty, force write back) sweeps the active
// frames through the single read port of the frame RAM, one frame per cycle;
// the active frame count is frames_in_use clamped to 1..NUM_FRAMES. When a
// stamp is taken for an LRU hit or an eviction while the stamp clock is above
// STAMP_LIMIT, the stamps are renormalized by two more sweeps over all
// NUM_FRAMES frames (minimum, then subtract) in that transaction. The block
// takes one transaction at a time; a finished result sits in an output
// register, so the next transaction is accepted while it waits. Frame valid
// bits are flip-flops cleared by reset, so no clearing pass is needed.
// Registers: replace_mode at byte address 0, frames_in_use at address 4.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module page_frame_table_fifo_lru_core #(
   parameter int NUM_FRAMES  = pfl_pkg::NUM_FRAMES_DEFAULT,
   parameter int PAGE_BITS   = pfl_pkg::PAGE_BITS_DEFAULT,
   parameter int STAMP_LIMIT = pfl_pkg::STAMP_LIMIT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   pfl_stream_if.sink                      req_chan,
   pfl_stream_if.source                    rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pfl_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pfl_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pfl_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import pfl_pkg::*;

   localparam int IDX_W      = $clog2(NUM_FRAMES);
   localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
   localparam int STORE_BITS = (PAGE_BITS < PAGE_FIELD_W) ? PAGE_BITS : PAGE_FIELD_W;
   localparam logic [CNT_W-1:0]   FRAME_COUNT = CNT_W'(NUM_FRAMES);
   localparam logic [CNT_W-1:0]   LAST_FRAME  = CNT_W'(NUM_FRAMES - 1);
   localparam logic [STAMP_W-1:0] STAMP_LIMIT_VALUE = STAMP_W'(STAMP_LIMIT);

   typedef struct packed {
      logic [STORE_BITS-1:0] page;
      logic [PIN_W-1:0]      pins;
      logic                  dirty;
      logic [STAMP_W-1:0]    stamp;
   } frame_word_type;

   localparam int WORD_W = $bits(frame_word_type);

   // Configuration registers.
   replace_mode_type  replace_mode_ff;
   logic [FIU_W-1:0]  frames_in_use_ff;
   reg_index_type     csr_index;
   logic              csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         replace_mode_ff  <= MODE_FIFO;
         frames_in_use_ff <= FRAMES_IN_USE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_REPLACE_MODE:  replace_mode_ff  <= replace_mode_type'(csr_pwdata[0]);
            REG_FRAMES_IN_USE: frames_in_use_ff <= csr_pwdata[FIU_W-1:0];
            default:           replace_mode_ff  <= replace_mode_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_REPLACE_MODE:  csr_prdata = CSR_DATA_W'(replace_mode_ff);
         REG_FRAMES_IN_USE: csr_prdata = CSR_DATA_W'(frames_in_use_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // A frame count of zero acts as one, and counts above the table size clamp.
   logic [CNT_W-1:0] active_frames;

   always_comb begin
      if (frames_in_use_ff == '0) begin
         active_frames = CNT_W'(1);
      end else if (int'(frames_in_use_ff) > NUM_FRAMES) begin
         active_frames = FRAME_COUNT;
      end else begin
         active_frames = CNT_W'(frames_in_use_ff);
      end
   end

   // Sequencer state.
   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [STORE_BITS-1:0] page_ff, page_in;
   logic [CNT_W-1:0]      last_ff, last_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;

   logic                  cmp_valid_ff, cmp_valid_in;
   pass_type              cmp_pass_ff, cmp_pass_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;

   logic                  hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   frame_word_type        hit_word_ff, hit_word_in;
   logic                  empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]      empty_idx_ff, empty_idx_in;
   logic                  vic_found_ff, vic_found_in;
   logic [IDX_W-1:0]      vic_idx_ff, vic_idx_in;
   frame_word_type        vic_word_ff, vic_word_in;

   logic [STAMP_W-1:0]    lo_ff, lo_in;
   logic [STAMP_W-1:0]    stamp_clock_ff, stamp_clock_in;
   logic [TOTAL_W-1:0]    reads_ff, reads_in;
   logic [TOTAL_W-1:0]    writes_ff, writes_in;
   logic [NUM_FRAMES-1:0] valid_ff, valid_in;

   logic [IDX_W-1:0]        tgt_idx_ff, tgt_idx_in;
   frame_word_type          tgt_word_ff, tgt_word_in;
   logic                    wr_mem_ff, wr_mem_in;
   logic                    fill_ff, fill_in;
   logic                    take_stamp_ff, take_stamp_in;
   status_type              status_ff, status_in;
   logic                    hit_out_ff, hit_out_in;
   logic                    wb_ff, wb_in;
   logic [PAGE_FIELD_W-1:0] wpage_ff, wpage_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   // Frame RAM port signals.
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [WORD_W-1:0]     rd_data;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   frame_word_type        wr_word;

   // Stamp comparator, shared by the scan and minimum sweeps, and stamp subtractor.
   frame_word_type        cmp_word;
   logic                  cmp_live;
   logic [STAMP_W-1:0]    cmp_ref;
   logic                  stamp_le;
   logic [STAMP_W-1:0]    stamp_diff;

   logic                  out_free;
   logic                  renorm_ok;
   frame_word_type        final_word;
   logic [TOTAL_W-1:0]    reads_next;
   logic [TOTAL_W-1:0]    writes_next;

   pfl_frame_ram #(
      .DEPTH  (NUM_FRAMES),
      .WORD_W (WORD_W)
   ) u_frame_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word)
   );

   assign cmp_word   = frame_word_type'(rd_data);
   assign cmp_live   = valid_ff[cmp_idx_ff];
   assign cmp_ref    = (cmp_pass_ff == PASS_MIN) ? lo_ff : vic_word_ff.stamp;
   assign stamp_le   = (cmp_word.stamp <= cmp_ref);
   assign stamp_diff = cmp_word.stamp - lo_ff;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      page_in        = page_ff;
      last_in        = last_ff;
      scan_in        = scan_ff;
      cmp_valid_in   = 1'b0;
      cmp_pass_in    = cmp_pass_ff;
      cmp_idx_in     = scan_ff[IDX_W-1:0];
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      hit_word_in    = hit_word_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      vic_found_in   = vic_found_ff;
      vic_idx_in     = vic_idx_ff;
      vic_word_in    = vic_word_ff;
      lo_in          = lo_ff;
      stamp_clock_in = stamp_clock_ff;
      reads_in       = reads_ff;
      writes_in      = writes_ff;
      valid_in       = valid_ff;
      tgt_idx_in     = tgt_idx_ff;
      tgt_word_in    = tgt_word_ff;
      wr_mem_in      = wr_mem_ff;
      fill_in        = fill_ff;
      take_stamp_in  = take_stamp_ff;
      status_in      = status_ff;
      hit_out_in     = hit_out_ff;
      wb_in          = wb_ff;
      wpage_in       = wpage_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;

      rd_en          = 1'b0;
      rd_addr        = scan_ff[IDX_W-1:0];
      wr_en          = 1'b0;
      wr_addr        = tgt_idx_ff;
      wr_word        = tgt_word_ff;
      renorm_ok      = 1'b0;
      final_word     = tgt_word_ff;
      reads_next     = reads_ff;
      writes_next    = writes_ff;

      out_free = !rsp_valid_ff || rsp_chan.ready;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Frame word returned by the RAM in the cycle after its read.
      if (cmp_valid_ff) begin
         case (cmp_pass_ff)
            PASS_SCAN: begin
               if (!hit_found_ff && cmp_live && cmp_word.page == page_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = cmp_idx_ff;
                  hit_word_in  = cmp_word;
               end
               if (!empty_found_ff && !cmp_live) begin
                  empty_found_in = 1'b1;
                  empty_idx_in   = cmp_idx_ff;
               end
               // Ties go to the later frame, hence the non-strict compare.
               if (cmp_live && cmp_word.pins == '0 && (!vic_found_ff || stamp_le)) begin
                  vic_found_in = 1'b1;
                  vic_idx_in   = cmp_idx_ff;
                  vic_word_in  = cmp_word;
               end
            end
            PASS_MIN: begin
               if (cmp_live && stamp_le) begin
                  lo_in = cmp_word.stamp;
               end
            end
            PASS_SUB: begin
               if (cmp_live) begin
                  wr_en         = 1'b1;
                  wr_addr       = cmp_idx_ff;
                  wr_word       = cmp_word;
                  wr_word.stamp = stamp_diff;
               end
            end
            default: begin
               lo_in = lo_ff;
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in          = req_chan.payload.operation;
               page_in        = req_chan.payload.page_number[STORE_BITS-1:0];
               last_in        = active_frames - CNT_W'(1);
               scan_in        = '0;
               hit_found_in   = 1'b0;
               empty_found_in = 1'b0;
               vic_found_in   = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en        = 1'b1;
            cmp_valid_in = 1'b1;
            cmp_pass_in  = PASS_SCAN;
            scan_in      = scan_ff + CNT_W'(1);
            if (scan_ff == last_ff) begin
               state_in = ST_SCAN_WAIT;
            end
         end
         ST_SCAN_WAIT: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            wr_mem_in     = 1'b0;
            fill_in       = 1'b0;
            take_stamp_in = 1'b0;
            status_in     = STATUS_OK;
            hit_out_in    = 1'b0;
            wb_in         = 1'b0;
            wpage_in      = '0;
            unique case (op_ff)
               OP_PIN: begin
                  if (hit_found_ff) begin
                     tgt_idx_in  = hit_idx_ff;
                     tgt_word_in = hit_word_ff;
                     if (hit_word_ff.pins != '1) begin
                        tgt_word_in.pins = hit_word_ff.pins + PIN_W'(1);
                     end
                     wr_mem_in     = 1'b1;
                     hit_out_in    = 1'b1;
                     take_stamp_in = (replace_mode_ff == MODE_LRU);
                     renorm_ok     = 1'b1;
                  end else if (empty_found_ff || vic_found_ff) begin
                     tgt_idx_in    = empty_found_ff ? empty_idx_ff : vic_idx_ff;
                     tgt_word_in   = '{page: page_ff, pins: PIN_W'(1), dirty: 1'b0,
                                       stamp: '0};
                     wr_mem_in     = 1'b1;
                     fill_in       = 1'b1;
                     take_stamp_in = 1'b1;
                     // Filling an empty frame evicts nothing, and renormalization is only
                     // started for an eviction.
                     renorm_ok     = !empty_found_ff;
                     if (!empty_found_ff && vic_word_ff.dirty) begin
                        wb_in    = 1'b1;
                        wpage_in = PAGE_FIELD_W'(vic_word_ff.page);
                     end
                  end else begin
                     status_in = STATUS_ALL_PINNED;
                  end
               end
               OP_UNPIN, OP_MARK_DIRTY, OP_FORCE: begin
                  if (hit_found_ff) begin
                     tgt_idx_in  = hit_idx_ff;
                     tgt_word_in = hit_word_ff;
                     wr_mem_in   = 1'b1;
                     if (op_ff == OP_UNPIN) begin
                        if (hit_word_ff.pins != '0) begin
                           tgt_word_in.pins = hit_word_ff.pins - PIN_W'(1);
                        end
                     end else if (op_ff == OP_MARK_DIRTY) begin
                        tgt_word_in.dirty = 1'b1;
                     end else begin
                        tgt_word_in.dirty = 1'b0;
                        wb_in             = 1'b1;
                        wpage_in          = PAGE_FIELD_W'(page_ff);
                     end
                  end else begin
                     status_in = STATUS_NOT_RESIDENT;
                  end
               end
               default: begin
                  status_in = STATUS_NOT_RESIDENT;
               end
            endcase
            if (take_stamp_in && renorm_ok && stamp_clock_ff > STAMP_LIMIT_VALUE) begin
               lo_in    = stamp_clock_ff;
               scan_in  = '0;
               state_in = ST_MIN;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_MIN: begin
            rd_en        = 1'b1;
            cmp_valid_in = 1'b1;
            cmp_pass_in  = PASS_MIN;
            scan_in      = scan_ff + CNT_W'(1);
            if (scan_ff == LAST_FRAME) begin
               state_in = ST_MIN_WAIT;
            end
         end
         ST_MIN_WAIT: begin
            scan_in  = '0;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            rd_en        = 1'b1;
            cmp_valid_in = 1'b1;
            cmp_pass_in  = PASS_SUB;
            scan_in      = scan_ff + CNT_W'(1);
            if (scan_ff == LAST_FRAME) begin
               state_in = ST_SUB_WAIT;
            end
         end
         ST_SUB_WAIT: begin
            stamp_clock_in = stamp_clock_ff - lo_ff;
            state_in       = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               if (take_stamp_ff) begin
                  final_word.stamp = stamp_clock_ff;
                  if (stamp_clock_ff != '1) begin
                     stamp_clock_in = stamp_clock_ff + STAMP_W'(1);
                  end
               end
               if (wr_mem_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = tgt_idx_ff;
                  wr_word = final_word;
               end
               if (fill_ff) begin
                  valid_in[tgt_idx_ff] = 1'b1;
                  reads_next           = reads_ff + TOTAL_W'(1);
               end
               if (wb_ff) begin
                  writes_next = writes_ff + TOTAL_W'(1);
               end
               reads_in  = reads_next;
               writes_in = writes_next;

               rsp_in.status       = status_ff;
               rsp_in.hit          = hit_out_ff;
               rsp_in.read_page    = fill_ff;
               rsp_in.write_back   = wb_ff;
               rsp_in.written_page = wpage_ff;
               rsp_in.read_total   = reads_next;
               rsp_in.write_total  = writes_next;
               if (status_ff == STATUS_OK) begin
                  rsp_in.frame_index = FRAME_FIELD_W'(tgt_idx_ff);
                  rsp_in.pin_count   = final_word.pins;
               end else begin
                  rsp_in.frame_index = '0;
                  rsp_in.pin_count   = '0;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cmp_valid_ff   <= 1'b0;
         valid_ff       <= '0;
         stamp_clock_ff <= '0;
         reads_ff       <= '0;
         writes_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cmp_valid_ff   <= cmp_valid_in;
         valid_ff       <= valid_in;
         stamp_clock_ff <= stamp_clock_in;
         reads_ff       <= reads_in;
         writes_ff      <= writes_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      page_ff        <= page_in;
      last_ff        <= last_in;
      scan_ff        <= scan_in;
      cmp_pass_ff    <= cmp_pass_in;
      cmp_idx_ff     <= cmp_idx_in;
      hit_found_ff   <= hit_found_in;
      hit_idx_ff     <= hit_idx_in;
      hit_word_ff    <= hit_word_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      vic_found_ff   <= vic_found_in;
      vic_idx_ff     <= vic_idx_in;
      vic_word_ff    <= vic_word_in;
      lo_ff          <= lo_in;
      tgt_idx_ff     <= tgt_idx_in;
      tgt_word_ff    <= tgt_word_in;
      wr_mem_ff      <= wr_mem_in;
      fill_ff        <= fill_in;
      take_stamp_ff  <= take_stamp_in;
      status_ff      <= status_in;
      hit_out_ff     <= hit_out_in;
      wb_ff          <= wb_in;
      wpage_ff       <= wpage_in;
      rsp_ff         <= rsp_in;
   end

   // The stamp clock only moves backward when renormalization finishes.
   `ASSERT_NEXT(a_stamp_clock_grows, clock, reset, state_ff != ST_SUB_WAIT, stamp_clock_ff >= $past(stamp_clock_ff), "stamp clock decreased outside renormalization")
   `ASSERT_IMPLY(a_hit_frame_valid, clock, reset, state_ff == ST_DECIDE && hit_found_ff, valid_ff[hit_idx_ff], "hit reported on a frame that is not valid")
   `ASSERT_IMPLY(a_no_write_in_scan, clock, reset, state_ff == ST_SCAN || state_ff == ST_SCAN_WAIT || state_ff == ST_MIN, !wr_en, "frame RAM written during a search sweep")
   `ASSERT_IMPLY(a_error_fields_clear, clock, reset, rsp_valid_ff && rsp_ff.status != STATUS_OK, rsp_ff.frame_index == '0 && rsp_ff.pin_count == '0 && !rsp_ff.read_page, "failed transaction reports frame data")

endmodule

// ----- dv/page_frame_table_fifo_lru_core_tb.sv -----
`timescale 1ns / 1ps

import pfl_pkg::*;

class frame_table_scoreboard;
   bit [PAGE_FIELD_W-1:0] slot_page[NUM_FRAMES_DEFAULT];
   bit                    slot_live[NUM_FRAMES_DEFAULT];
   bit [PIN_W-1:0]        slot_pins[NUM_FRAMES_DEFAULT];
   bit                    slot_dirty[NUM_FRAMES_DEFAULT];
   bit [STAMP_W-1:0]      slot_age[NUM_FRAMES_DEFAULT];
   bit [STAMP_W-1:0]      age_clock;
   bit [TOTAL_W-1:0]      pages_read;
   bit [TOTAL_W-1:0]      pages_written;
   replace_mode_type      policy = MODE_FIFO;
   bit [FIU_W-1:0]        frame_limit = FRAMES_IN_USE_RESET;
   rsp_type               pending_results[$];
   int                    mismatches;

   function void set_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      if (idx == REG_REPLACE_MODE)
         policy = replace_mode_type'(value[0]);
      else
         frame_limit = value[FIU_W-1:0];
   endfunction

   function int active_count();
      if (frame_limit == 0)
         return 1;
      if (frame_limit > NUM_FRAMES_DEFAULT)
         return NUM_FRAMES_DEFAULT;
      return int'(frame_limit);
   endfunction

   // Picks a page held by one of the searched frames, so that hits are frequent.
   function bit pick_resident(output logic [PAGE_FIELD_W-1:0] page);
      int live_idx[$];
      int i;
      for (i = 0; i < active_count(); i++)
         if (slot_live[i])
            live_idx.push_back(i);
      if (live_idx.size() == 0)
         return 1'b0;
      page = slot_page[live_idx[$urandom_range(live_idx.size() - 1)]];
      return 1'b1;
   endfunction

   // Once the clock passes the limit, every live stamp is shifted down by the oldest one.
   function void restamp(int f);
      bit [STAMP_W-1:0] oldest;
      int i;
      if (age_clock > STAMP_LIMIT_DEFAULT) begin
         oldest = age_clock;
         for (i = 0; i < NUM_FRAMES_DEFAULT; i++)
            if (slot_live[i] && slot_age[i] < oldest)
               oldest = slot_age[i];
         for (i = 0; i < NUM_FRAMES_DEFAULT; i++)
            if (slot_live[i])
               slot_age[i] = slot_age[i] - oldest;
         age_clock = age_clock - oldest;
      end
      slot_age[f] = age_clock;
      if (age_clock != {STAMP_W{1'b1}})
         age_clock = age_clock + 1'b1;
   endfunction

   function void accept_request(req_type req);
      rsp_type res;
      int n, f, slot, best, i;
      n = active_count();
      res = '0;
      f = -1;
      for (i = 0; i < n; i++)
         if (f < 0 && slot_live[i] && slot_page[i] == req.page_number)
            f = i;
      if (req.operation == OP_PIN) begin
         if (f >= 0) begin
            if (slot_pins[f] != {PIN_W{1'b1}})
               slot_pins[f]++;
            if (policy == MODE_LRU)
               restamp(f);
            res.hit = 1'b1;
         end else begin
            slot = -1;
            for (i = 0; i < n; i++)
               if (slot < 0 && !slot_live[i])
                  slot = i;
            if (slot < 0) begin
               // Ties on the oldest stamp go to the highest index.
               best = 1 << STAMP_W;
               for (i = 0; i < n; i++)
                  if (slot_pins[i] == 0 && slot_age[i] <= best) begin
                     best = slot_age[i];
                     slot = i;
                  end
               if (slot >= 0 && slot_dirty[slot]) begin
                  res.write_back = 1'b1;
                  res.written_page = slot_page[slot];
                  pages_written++;
               end
            end
            if (slot < 0) begin
               res.status = STATUS_ALL_PINNED;
            end else begin
               slot_live[slot] = 1'b1;
               slot_page[slot] = req.page_number;
               slot_pins[slot] = PIN_W'(1);
               slot_dirty[slot] = 1'b0;
               restamp(slot);
               pages_read++;
               res.read_page = 1'b1;
               f = slot;
            end
         end
      end else if (f < 0) begin
         res.status = STATUS_NOT_RESIDENT;
      end else begin
         case (req.operation)
            OP_UNPIN: begin
               if (slot_pins[f] != 0)
                  slot_pins[f]--;
            end
            OP_MARK_DIRTY: begin
               slot_dirty[f] = 1'b1;
            end
            default: begin
               res.write_back = 1'b1;
               res.written_page = req.page_number;
               pages_written++;
               slot_dirty[f] = 1'b0;
            end
         endcase
      end
      if (res.status == STATUS_OK && f >= 0) begin
         res.frame_index = FRAME_FIELD_W'(f);
         res.pin_count = slot_pins[f];
      end
      res.read_total = pages_read;
      res.write_total = pages_written;
      pending_results.push_back(res);
   endfunction

   function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         $error("result transaction arrived with no request outstanding");
         mismatches++;
         return;
      end
      want = pending_results.pop_front();
      compare_field("frame_index", want.frame_index, got.frame_index);
      compare_field("status", want.status, got.status);
      compare_field("hit", want.hit, got.hit);
      compare_field("read_page", want.read_page, got.read_page);
      compare_field("write_back", want.write_back, got.write_back);
      compare_field("written_page", want.written_page, got.written_page);
      compare_field("pin_count", want.pin_count, got.pin_count);
      compare_field("read_total", want.read_total, got.read_total);
      compare_field("write_total", want.write_total, got.write_total);
   endfunction
endclass

module page_frame_table_fifo_lru_core_tb;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int END_WAIT        = 100;
   localparam int PHASE_ITEMS     = 165;
   localparam int HAMMER_ITEMS    = 400;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   frame_table_scoreboard sb = new;
   logic [PAGE_FIELD_W-1:0] page_pool[32];
   int idle_pct;
   int stall_pct;
   int hold_off_asked;
   int hold_off_seen;
   int hold_left;
   int quiet_cycles;

   pfl_stream_if #(.payload_type(req_type)) req_chan ();
   pfl_stream_if #(.payload_type(rsp_type)) rsp_chan ();

   page_frame_table_fifo_lru_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Result side: check every accepted transaction, then pick the next ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_off_seen <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_result(rsp_chan.payload);
         if (hold_off_seen != hold_off_asked) begin
            hold_off_seen <= hold_off_asked;
            hold_left <= HOLD_OFF_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL page_frame_table_fifo_lru_core");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_op(op_type op, logic [PAGE_FIELD_W-1:0] page);
      req_type req;
      req.operation = op;
      req.page_number = page;
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= req;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      sb.accept_request(req);
   endtask

   // Lowers valid and holds off until every outstanding transaction has returned.
   task automatic await_results();
      req_chan.valid <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending_results.size() != 0);
   endtask

   task automatic write_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      sb.set_register(idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic reconfigure(replace_mode_type mode, int frames);
      await_results();
      repeat (4) @(posedge clock);
      write_register(REG_REPLACE_MODE, CSR_DATA_W'(mode));
      write_register(REG_FRAMES_IN_USE, CSR_DATA_W'(frames));
   endtask

   task automatic run_phase(int items, int idle, int stall, bit with_hold_off, bit with_pauses);
      op_type op;
      logic [PAGE_FIELD_W-1:0] page;
      int k, pick, reach;
      idle_pct = idle;
      stall_pct <= stall;
      for (k = 0; k < items; k++) begin
         if (with_hold_off && k == 20)
            hold_off_asked <= hold_off_asked + 1;
         if (with_pauses && k % 40 == 39)
            await_results();
         pick = $urandom_range(99);
         if (pick < 40)
            op = OP_PIN;
         else if (pick < 70)
            op = OP_UNPIN;
         else if (pick < 85)
            op = OP_MARK_DIRTY;
         else
            op = OP_FORCE;
         pick = $urandom_range(99);
         reach = 2 * sb.active_count() + 3;
         if (reach > 31)
            reach = 31;
         page = page_pool[$urandom_range(reach)];
         if (pick < ((op == OP_PIN) ? 35 : 75)) begin
            if (!sb.pick_resident(page))
               page = page_pool[$urandom_range(reach)];
         end else if (pick >= 95) begin
            page = PAGE_FIELD_W'($urandom);
         end
         send_op(op, page);
      end
   endtask

   initial begin
      op_type op;
      logic [PAGE_FIELD_W-1:0] page;
      int i;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      idle_pct = 0;
      stall_pct <= 0;
      hold_off_asked <= 0;
      page_pool[0] = '0;
      page_pool[1] = '1;
      for (i = 2; i < 32; i++)
         page_pool[i] = PAGE_FIELD_W'($urandom);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part, starting from the reset settings: FIFO over all sixteen frames.
      send_op(OP_UNPIN, 16'h0000);
      send_op(OP_MARK_DIRTY, 16'hFFFF);
      send_op(OP_FORCE, 16'h8001);
      send_op(OP_PIN, 16'h0000);
      send_op(OP_PIN, 16'hFFFF);
      send_op(OP_PIN, 16'h0000);
      repeat (3) send_op(OP_UNPIN, 16'h0000);
      send_op(OP_MARK_DIRTY, 16'h0000);
      send_op(OP_FORCE, 16'hFFFF);

      // Two frames: a dirty victim, then every frame pinned.
      reconfigure(MODE_LRU, 2);
      send_op(OP_PIN, 16'h1234);
      send_op(OP_PIN, 16'h1234);
      send_op(OP_PIN, 16'hABCD);
      send_op(OP_UNPIN, 16'hFFFF);
      send_op(OP_PIN, 16'hABCD);

      // A count of zero searches one frame; the page in frame one is out of reach.
      reconfigure(MODE_FIFO, 0);
      send_op(OP_PIN, 16'hFFFF);
      send_op(OP_MARK_DIRTY, 16'hABCD);
      send_op(OP_UNPIN, 16'h1234);
      send_op(OP_UNPIN, 16'h1234);
      send_op(OP_PIN, 16'h5A5A);
      reconfigure(MODE_FIFO, 31);
      send_op(OP_PIN, 16'hABCD);

      reconfigure(MODE_FIFO, 16);
      run_phase(PHASE_ITEMS, 0, 0, 1'b1, 1'b0);
      reconfigure(MODE_LRU, 16);
      run_phase(PHASE_ITEMS, 79, 0, 1'b0, 1'b0);
      reconfigure(MODE_FIFO, 1);
      run_phase(PHASE_ITEMS, 0, 79, 1'b0, 1'b0);
      reconfigure(MODE_LRU, 0);
      run_phase(PHASE_ITEMS, 33, 33, 1'b0, 1'b0);
      reconfigure(MODE_LRU, 4);
      run_phase(PHASE_ITEMS, 0, 0, 1'b0, 1'b1);
      reconfigure(MODE_FIFO, 31);
      run_phase(PHASE_ITEMS, 79, 0, 1'b0, 1'b0);
      reconfigure(MODE_LRU, 17);
      run_phase(PHASE_ITEMS, 0, 79, 1'b0, 1'b0);
      reconfigure(MODE_FIFO, 3);
      run_phase(PHASE_ITEMS, 33, 33, 1'b0, 1'b0);

      // Hammer a single frame under LRU, mostly with pins, so that its pin count
      // saturates along the way.
      reconfigure(MODE_LRU, 1);
      idle_pct = 0;
      stall_pct <= 0;
      repeat (HAMMER_ITEMS) begin
         if (sb.pick_resident(page)) begin
            op = ($urandom_range(9) == 0) ? OP_UNPIN : OP_PIN;
         end else begin
            op = OP_PIN;
            page = PAGE_FIELD_W'($urandom);
         end
         send_op(op, page);
      end

      await_results();
      repeat (END_WAIT) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0)
         $display("PASS page_frame_table_fifo_lru_core");
      else
         $display("FAIL page_frame_table_fifo_lru_core");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pfl_pkg.sv
rtl/pfl_stream_if.sv
rtl/pfl_frame_ram.sv
rtl/page_frame_table_fifo_lru_core.sv
dv/page_frame_table_fifo_lru_core_tb.sv
